/* rtl/pixel_color_effect_assert.svh */
`ifndef PIXEL_COLOR_EFFECT_ASSERT_SVH
`define PIXEL_COLOR_EFFECT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define PCE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define PCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pce_pkg.sv */
package pce_pkg;

    typedef enum logic [2:0] {
        MODE_SEPIA  = 3'd0,
        MODE_RED    = 3'd1,
        MODE_GREEN  = 3'd2,
        MODE_BLUE   = 3'd3,
        MODE_COMIC  = 3'd4,
        MODE_CAST   = 3'd5,
        MODE_INVERT = 3'd6,
        MODE_FROZEN = 3'd7
    } t_mode;

    // apb byte address width, bit 2 and up select the register
    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_EFFECT_MODE = '0;

    // one color channel on its way through the divider stages
    typedef struct packed {
        logic       use_quo;
        logic [7:0] direct;
        logic [8:0] dvsr;
        logic [8:0] rem;
        logic       feed;
        logic [7:0] quo;
    } t_lane;

    typedef struct packed {
        t_lane blue;
        t_lane green;
        t_lane red;
        logic  eoi;
    } t_word;

endpackage

/* rtl/pce_pix_if.sv */
interface pce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       end_of_image;

    modport source (output valid, blue_in, green_in, red_in, end_of_image, input ready);
    modport sink (input valid, blue_in, green_in, red_in, end_of_image, output ready);
endinterface

interface pce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       end_of_image_out;

    modport source (output valid, blue_out, green_out, red_out, end_of_image_out, input ready);
    modport sink (input valid, blue_out, green_out, red_out, end_of_image_out, output ready);
endinterface

/* rtl/pce_cfg.sv */
module pce_cfg import pce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_mode              o_mode
);

    t_mode r_mode;
    logic  sel_mode;
    logic  wr_mode;

    assign sel_mode = (paddr[PADDR_W-1:2] == REG_EFFECT_MODE);
    assign pready   = 1'b1;
    assign wr_mode  = psel && penable && pwrite && pready && sel_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SEPIA;
        end else if (wr_mode) begin
            r_mode <= t_mode'(pwdata[2:0]);
        end
    end

    assign prdata = sel_mode ? {29'd0, r_mode} : 32'd0;
    assign o_mode = r_mode;

endmodule

/* rtl/pce_front.sv */
module pce_front import pce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en_mix,
    input  logic       i_en_sel,
    input  t_mode      i_mode,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    input  logic       i_eoi,
    output t_word      o_word
);

    localparam int unsigned NCH = 3;
    localparam int unsigned CH_BLUE = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_RED = 2;

    // q16 sepia weights, [output channel][input channel], channels blue, green, red
    localparam logic [15:0] SEPIA_K [NCH][NCH] = '{
        '{16'd8585,  16'd34996, 16'd17826},
        '{16'd11010, 16'd44958, 16'd22872},
        '{16'd12386, 16'd50397, 16'd25756}
    };
    localparam logic [24:0] ROUND_HALF = 25'd32768;

    function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] clip8(input logic [9:0] v);
        return (v > 10'd255) ? 8'hFF : v[7:0];
    endfunction

    logic [7:0]  pix [NCH];
    logic [8:0]  osum [NCH];
    logic [9:0]  fabs [NCH];
    logic [10:0] f3 [NCH];
    logic [9:0]  mix1;
    logic [9:0]  mix2;

    logic [23:0] r_prod [NCH][NCH];
    logic [7:0]  r_pix [NCH];
    logic [8:0]  r_dvsr [NCH];
    logic [7:0]  r_frz [NCH];
    logic [9:0]  r_m1;
    logic [9:0]  r_m2;
    logic        r_eoi;

    logic [24:0] sep_sum [NCH];
    logic [7:0]  sep8 [NCH];
    logic [17:0] cprod [NCH];
    logic [7:0]  comic8 [NCH];
    logic        csat [NCH];
    t_lane       lane [NCH];
    t_word       n_word;
    t_word       r_word;

    // first stage: sepia partial products, channel mixes, frozen result
    always_comb begin
        pix[CH_BLUE]  = i_blue;
        pix[CH_GREEN] = i_green;
        pix[CH_RED]   = i_red;
        osum[CH_BLUE]  = 9'(i_green) + 9'(i_red);
        osum[CH_GREEN] = 9'(i_red) + 9'(i_blue);
        osum[CH_RED]   = 9'(i_blue) + 9'(i_green);
        for (int k = 0; k < NCH; k++) begin
            fabs[k] = abs_diff({2'b00, pix[k]}, {1'b0, osum[k]});
            f3[k]   = 11'(fabs[k]) + {fabs[k], 1'b0};
        end
        mix1 = abs_diff({1'b0, i_blue, 1'b0} + {2'b00, i_red}, {2'b00, i_green});
        mix2 = abs_diff({1'b0, i_green, 1'b0} + {2'b00, i_red}, {2'b00, i_blue});
    end

    always_ff @(posedge i_clk) begin
        if (i_en_mix) begin
            for (int o = 0; o < NCH; o++) begin
                for (int k = 0; k < NCH; k++) begin
                    r_prod[o][k] <= 24'(SEPIA_K[o][k]) * 24'(pix[k]);
                end
                r_pix[o]  <= pix[o];
                r_dvsr[o] <= osum[o] + 9'd1;
                r_frz[o]  <= clip8(f3[o][10:1]);
            end
            r_m1  <= mix1;
            r_m2  <= mix2;
            r_eoi <= i_eoi;
        end
    end

    // second stage: sums, comic products, effect select, divider setup
    always_comb begin
        cprod[CH_BLUE]  = 18'(r_m1) * 18'(r_pix[CH_GREEN]);
        cprod[CH_GREEN] = 18'(r_m1) * 18'(r_pix[CH_RED]);
        cprod[CH_RED]   = 18'(r_m2) * 18'(r_pix[CH_RED]);
        for (int k = 0; k < NCH; k++) begin
            sep_sum[k] = 25'(r_prod[k][0]) + 25'(r_prod[k][1]) + 25'(r_prod[k][2])
                       + ROUND_HALF;
            sep8[k]    = sep_sum[k][24] ? 8'hFF : sep_sum[k][23:16];
            comic8[k]  = (cprod[k][17:16] != 2'b00) ? 8'hFF : cprod[k][15:8];
            csat[k]    = ({2'b00, r_pix[k]} >= {r_dvsr[k], 1'b0});

            lane[k].dvsr    = r_dvsr[k];
            lane[k].rem     = {2'b00, r_pix[k][7:1]};
            lane[k].feed    = r_pix[k][0];
            lane[k].quo     = 8'd0;
            lane[k].use_quo = 1'b0;
            unique case (i_mode)
                MODE_SEPIA:  lane[k].direct = sep8[k];
                MODE_RED:    lane[k].direct = (k == CH_RED) ? r_pix[k] : 8'd0;
                MODE_GREEN:  lane[k].direct = (k == CH_GREEN) ? r_pix[k] : 8'd0;
                MODE_BLUE:   lane[k].direct = (k == CH_BLUE) ? r_pix[k] : 8'd0;
                MODE_COMIC:  lane[k].direct = comic8[k];
                MODE_CAST: begin
                    // quotient saturates when c >= 2*(divisor)
                    lane[k].direct  = 8'hFF;
                    lane[k].use_quo = !csat[k];
                end
                MODE_INVERT: lane[k].direct = ~r_pix[k];
                MODE_FROZEN: lane[k].direct = r_frz[k];
            endcase
        end
        n_word.blue  = lane[CH_BLUE];
        n_word.green = lane[CH_GREEN];
        n_word.red   = lane[CH_RED];
        n_word.eoi   = r_eoi;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sel) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/pce_div.sv */
module pce_div import pce_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_word,
    output t_word o_word
);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_lane div_step(input t_lane l);
        logic [9:0] part;
        logic [9:0] dv;
        logic [9:0] diff;
        logic       ge;
        t_lane      n;
        part   = {l.rem, l.feed};
        dv     = {1'b0, l.dvsr};
        diff   = part - dv;
        ge     = (part >= dv);
        n      = l;
        n.rem  = ge ? diff[8:0] : part[8:0];
        n.quo  = {l.quo[6:0], ge};
        n.feed = 1'b0;
        return n;
    endfunction

    t_word n_word;
    t_word r_word;

    always_comb begin
        n_word       = i_word;
        n_word.blue  = div_step(div_step(i_word.blue));
        n_word.green = div_step(div_step(i_word.green));
        n_word.red   = div_step(div_step(i_word.red));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

/* rtl/pixel_color_effect.sv */
// channel   dir   handshake       word contents
// i_pix     in    valid/ready     blue_in, green_in, red_in, end_of_image
// o_pix     out   valid/ready     blue_out, green_out, red_out, end_of_image_out
// apb       in    psel/penable    effect_mode at byte address 0, pready always high
//
// one word per clock sustained while o_pix is ready, seven register stages; o_pix.valid
// rises once a word accepted on i_pix has passed through all seven
// the casting divider fills four stages of two quotient bits each
// i_rst_n is synchronous; it empties every stage and sets effect_mode to sepia
// a stage moves when it is empty or the one after it moves, so a stalled o_pix
// backs up stage by stage and i_pix.ready drops only when all seven are full

`include "pixel_color_effect_assert.svh"

module pixel_color_effect import pce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pce_in_if.sink             i_pix,
    pce_out_if.source          o_pix,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // two front stages, the divider stages, then the output register
    localparam int unsigned NUM_DIV = 4;
    localparam int unsigned NUM_STG = NUM_DIV + 3;
    localparam int unsigned STG_OUT = NUM_STG - 1;

    t_mode              mode;
    logic [NUM_STG-1:0] en;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] r_vld;
    t_word              w_div [NUM_DIV+1];
    t_word              w_last;

    logic [7:0] r_blue_out;
    logic [7:0] r_green_out;
    logic [7:0] r_red_out;
    logic       r_eoi_out;

    // effect mode register on the apb side
    pce_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode)
    );

    // stage enables: ripple back from the output so bubbles get squeezed out
    always_comb begin
        en[STG_OUT] = !r_vld[STG_OUT] || o_pix.ready;
        for (int k = STG_OUT - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_pix.valid : r_vld[0];
        for (int k = 1; k < NUM_STG; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = en[0];

    // stages 0 and 1: products, mixes and effect select
    pce_front u_front (
        .i_clk    (i_clk),
        .i_en_mix (en[0]),
        .i_en_sel (en[1]),
        .i_mode   (mode),
        .i_blue   (i_pix.blue_in),
        .i_green  (i_pix.green_in),
        .i_red    (i_pix.red_in),
        .i_eoi    (i_pix.end_of_image),
        .o_word   (w_div[0])
    );

    // casting divide, two quotient bits per stage on all three channels
    for (genvar s = 0; s < NUM_DIV; s++) begin : g_div
        pce_div u_div (
            .i_clk  (i_clk),
            .i_en   (en[s+2]),
            .i_word (w_div[s]),
            .o_word (w_div[s+1])
        );
    end

    assign w_last = w_div[NUM_DIV];

    // output register: quotient for unsaturated casting, the direct value otherwise
    always_ff @(posedge i_clk) begin
        if (en[STG_OUT]) begin
            r_blue_out  <= w_last.blue.use_quo ? w_last.blue.quo : w_last.blue.direct;
            r_green_out <= w_last.green.use_quo ? w_last.green.quo : w_last.green.direct;
            r_red_out   <= w_last.red.use_quo ? w_last.red.quo : w_last.red.direct;
            r_eoi_out   <= w_last.eoi;
        end
    end

    assign o_pix.valid            = r_vld[STG_OUT];
    assign o_pix.blue_out         = r_blue_out;
    assign o_pix.green_out        = r_green_out;
    assign o_pix.red_out          = r_red_out;
    assign o_pix.end_of_image_out = r_eoi_out;

    // backpressure reaches the input only with every stage full
    `PCE_ASSERT_NOW(a_full_when_blocked, !i_pix.ready, &r_vld, "input blocked with a free stage")
    // an accepted word lands in the first stage
    `PCE_ASSERT_NEXT(a_accept_fills, i_pix.valid && i_pix.ready, r_vld[0], "accepted word lost")
    // a result that was not taken stays valid, with blue and red unchanged
    `PCE_ASSERT_NEXT(a_out_holds, r_vld[STG_OUT] && !o_pix.ready,
        r_vld[STG_OUT] && $stable(r_blue_out) && $stable(r_red_out), "stalled result changed")

endmodule

/* dv/pixel_color_effect_test.sv */
`timescale 1ns / 1ps

module pixel_color_effect_test;
    import pce_pkg::*;

    localparam int unsigned HALF_PERIOD   = 6;
    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned IDLE_PERCENT  = 22;
    localparam int unsigned WORDS_PER_SET = 150;
    localparam int unsigned RANDOM_SETS   = 10;
    localparam int unsigned SETTLE_CYCLES = 12;   // margin once every expected word is back
    localparam int unsigned HOLD_CYCLES   = 48;   // long back-pressure burst on o_pix
    localparam int unsigned HOLD_AFTER    = 600;  // words checked before the burst
    localparam int unsigned QUIET_LIMIT   = 1000;
    localparam int unsigned REPORT_LIMIT  = 10;

    // register map: effect_mode at its index, anything else is a dead address
    localparam logic [PADDR_W-1:0] ADDR_MODE  = {REG_EFFECT_MODE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_EFFECT_MODE, 2'b00};

    // sepia weights in q16, ordered red, green, blue
    localparam int SEPIA_TO_RED[3]   = '{25756, 50397, 12386};
    localparam int SEPIA_TO_GREEN[3] = '{22872, 44958, 11010};
    localparam int SEPIA_TO_BLUE[3]  = '{17826, 34996, 8585};
    localparam int Q16_HALF          = 32768;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       eoi;
    } t_pixel;

    // expected recolored words, in order, plus the mode the block should be in
    class recolor_scoreboard;
        t_mode       mode;
        t_pixel      recolored[$];
        int unsigned noted;
        int unsigned checked;
        int unsigned failures;

        function new();
            mode = MODE_SEPIA;
            noted = 0;
            checked = 0;
            failures = 0;
        endfunction

        function void flag(string what, int want, int got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("mismatch %s: expected %0d, got %0d (word %0d, mode %s)",
                         what, want, got, checked, mode.name());
        endfunction

        function int pending();
            return recolored.size();
        endfunction

        function int clip(int v);
            return (v > 255) ? 255 : v;
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int sepia(int k[3], int r, int g, int b);
            return clip((k[0] * r + k[1] * g + k[2] * b + Q16_HALF) >>> 16);
        endfunction

        function t_pixel recolor(t_pixel p);
            int     b, g, r, m1, m2;
            t_pixel q;
            b = p.blue;
            g = p.green;
            r = p.red;
            q = '0;
            q.eoi = p.eoi;
            case (mode)
                MODE_SEPIA: begin
                    q.red   = 8'(sepia(SEPIA_TO_RED, r, g, b));
                    q.green = 8'(sepia(SEPIA_TO_GREEN, r, g, b));
                    q.blue  = 8'(sepia(SEPIA_TO_BLUE, r, g, b));
                end
                MODE_RED:   q.red = p.red;
                MODE_GREEN: q.green = p.green;
                MODE_BLUE:  q.blue = p.blue;
                MODE_COMIC: begin
                    m1 = magnitude(2 * b - g + r);
                    m2 = magnitude(2 * g - b + r);
                    q.blue  = 8'(clip((m1 * g) >>> 8));
                    q.green = 8'(clip((m1 * r) >>> 8));
                    q.red   = 8'(clip((m2 * r) >>> 8));
                end
                MODE_CAST: begin
                    q.blue  = 8'(clip((b * 128) / (g + r + 1)));
                    q.green = 8'(clip((g * 128) / (r + b + 1)));
                    q.red   = 8'(clip((r * 128) / (b + g + 1)));
                end
                MODE_INVERT: begin
                    q.blue  = ~p.blue;
                    q.green = ~p.green;
                    q.red   = ~p.red;
                end
                default: begin
                    q.blue  = 8'(clip((magnitude(b - r - g) * 3) / 2));
                    q.green = 8'(clip((magnitude(g - r - b) * 3) / 2));
                    q.red   = 8'(clip((magnitude(r - g - b) * 3) / 2));
                end
            endcase
            return q;
        endfunction

        function void note_pixel(t_pixel p);
            recolored.push_back(recolor(p));
            noted++;
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (recolored.size() == 0) begin
                flag("unexpected word", 0, 1);
                return;
            end
            want = recolored.pop_front();
            if (got.blue !== want.blue)   flag("blue_out", want.blue, got.blue);
            if (got.green !== want.green) flag("green_out", want.green, got.green);
            if (got.red !== want.red)     flag("red_out", want.red, got.red);
            if (got.eoi !== want.eoi)     flag("end_of_image_out", want.eoi, got.eoi);
            checked++;
        endfunction

        function void check_mode(logic [2:0] got);
            if (got !== mode) flag("effect_mode readback", mode, got);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          steady;   // set for a stretch with no idling on either side

    recolor_scoreboard sb = new();

    pce_in_if  pix_in ();
    pce_out_if pix_out ();

    pixel_color_effect u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // corner words, three per effect: all-zero, all-full, one hot channels,
    // negative mixes for comic and frozen, a zero sum under casting
    t_pixel corner[24] = '{
        '{8'd0,   8'd0,   8'd0,   1'b0}, '{8'd255, 8'd255, 8'd255, 1'b1},
        '{8'd1,   8'd2,   8'd3,   1'b0},
        '{8'd0,   8'd0,   8'd255, 1'b0}, '{8'd255, 8'd255, 8'd0,   1'b1},
        '{8'd170, 8'd85,  8'd170, 1'b0},
        '{8'd0,   8'd255, 8'd0,   1'b0}, '{8'd255, 8'd0,   8'd255, 1'b0},
        '{8'd85,  8'd170, 8'd85,  1'b1},
        '{8'd255, 8'd0,   8'd0,   1'b0}, '{8'd0,   8'd255, 8'd255, 1'b0},
        '{8'd170, 8'd85,  8'd170, 1'b1},
        '{8'd0,   8'd255, 8'd0,   1'b0}, '{8'd255, 8'd0,   8'd255, 1'b0},
        '{8'd255, 8'd255, 8'd255, 1'b1},
        '{8'd0,   8'd0,   8'd0,   1'b0}, '{8'd255, 8'd0,   8'd0,   1'b0},
        '{8'd1,   8'd255, 8'd255, 1'b1},
        '{8'd0,   8'd0,   8'd0,   1'b0}, '{8'd255, 8'd255, 8'd255, 1'b0},
        '{8'd15,  8'd240, 8'd90,  1'b1},
        '{8'd0,   8'd255, 8'd255, 1'b0}, '{8'd255, 8'd0,   8'd0,   1'b0},
        '{8'd100, 8'd60,  8'd40,  1'b1}
    };

    // channel values lean toward the ends so saturation and zero show up often
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 15));
            3:       return 8'($urandom_range(240, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel p;
        p.blue  = random_channel();
        p.green = random_channel();
        p.red   = random_channel();
        p.eoi   = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    // offer one word on i_pix, with random gaps ahead of it, and wait for acceptance
    // valid stays high from one word to the next unless a gap comes in between
    task automatic send_pixel(input t_pixel p);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid        <= 1'b1;
        pix_in.blue_in      <= p.blue;
        pix_in.green_in     <= p.green;
        pix_in.red_in       <= p.red;
        pix_in.end_of_image <= p.eoi;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        sb.note_pixel(p);
    endtask

    // setup cycle, then access cycle; pready is tied high but is honored anyway
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_MODE) sb.mode = t_mode'(data[2:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read effect_mode back; only its three bits carry meaning
    task automatic apb_check_mode();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MODE;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.check_mode(prdata[2:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper data bits are junk on purpose, the block keeps only the low three
    task automatic set_effect(input t_mode m);
        logic [31:0] data;
        data = $urandom;
        data[2:0] = m;
        apb_write(ADDR_MODE, data);
        apb_check_mode();
    endtask

    // stop offering, let every expected word come back, then give the pipe a margin
    task automatic drain_words();
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // main sequence: reset, corner words under every effect, then random sets
    initial begin : stimulus
        int unsigned set_idx;
        int unsigned n;
        t_mode       m;
        steady               = 1'b0;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        pix_in.valid         = 1'b0;
        pix_in.blue_in       = '0;
        pix_in.green_in      = '0;
        pix_in.red_in        = '0;
        pix_in.end_of_image  = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first group runs on the reset mode, sepia, with no write ahead of it
        apb_check_mode();
        for (set_idx = 0; set_idx < 8; set_idx++) begin
            if (set_idx != 0) set_effect(t_mode'(set_idx));
            for (n = 0; n < 3; n++) send_pixel(corner[3 * set_idx + n]);
            drain_words();
        end

        // every effect once in order, then two picked at random
        for (set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
            m = (set_idx < 8) ? t_mode'(set_idx) : t_mode'($urandom_range(0, 7));
            // a write to the dead address must leave effect_mode alone
            if (set_idx % 3 == 1) begin
                apb_write(ADDR_SPARE, $urandom);
                apb_check_mode();
            end
            set_effect(m);
            steady = (set_idx == 2);
            for (n = 0; n < WORDS_PER_SET; n++) send_pixel(random_pixel());
            drain_words();
        end
        steady = 1'b0;

        if (sb.pending() != 0) sb.flag("words never returned", 0, sb.pending());
        $display("%0d words sent through all eight effects, %0d recolored words checked",
                 sb.noted, sb.checked);
        $display("register writes with junk upper bits, a dead address and one long stall");
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // o_pix ready: random holdoff, one long burst once enough words went through
    initial begin : receiver
        int unsigned hold_left;
        bit          held_once;
        hold_left = 0;
        held_once = 1'b0;
        pix_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_once && sb.checked >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end else if (steady || !i_rst_n) begin
                pix_out.ready <= i_rst_n;
            end else begin
                pix_out.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // collect every word leaving the block
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            sb.check_pixel('{pix_out.blue_out, pix_out.green_out, pix_out.red_out,
                             pix_out.end_of_image_out});
    end

    // watchdog: too many cycles with no word moving on any port
    int unsigned quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
